>>> rtl/leds_pkg.sv
// Shared types and constants for the LOOK elevator disk scheduler.
// No dependencies; imported by every other file of the block but leds_ram.
`timescale 1ns / 1ps

package leds_pkg;

  localparam int unsigned SEEK_W    = 14;
  localparam int unsigned SEEK_MAX  = 16383;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_UPWARD   = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input word taken
    logic start;      // batch end word taken, begin scheduling
    logic scan;       // issue one pending-table read
    logic serve;      // commit best candidate to the output register
    logic flip;       // reverse sweep direction and rescan
    logic next_scan;  // output word taken, more to serve
    logic clear;      // batch done, drop all entries
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_last;
    logic scan_end;
    logic found;
    logic flipped;
    logic out_last;
  } sts_t;

endpackage

>>> rtl/leds_if.sv
// Valid/ready channel interfaces for request words and result words.
// Depends on leds_pkg.
`timescale 1ns / 1ps

interface leds_req_if #(
  parameter int unsigned TRACK_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] request_track;
  logic                  batch_end;

  modport source (output valid, request_track, batch_end, input ready);
  modport sink   (input valid, request_track, batch_end, output ready);
endinterface

interface leds_res_if #(
  parameter int unsigned TRACK_BITS = 10
);
  import leds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TRACK_BITS-1:0] served_track;
  logic [TRACK_BITS-1:0] distance_moved;
  logic [SEEK_W-1:0]     seek_total;
  logic                  run_last;

  modport source (output valid, served_track, distance_moved, seek_total, run_last,
                  input ready);
  modport sink   (input valid, served_track, distance_moved, seek_total, run_last,
                  output ready);
endinterface

>>> rtl/leds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module leds_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/leds_ctrl.sv
// Sequencing state machine: load, scan, decide, emit.
// Depends on leds_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module leds_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  leds_pkg::sts_t sts,
  output leds_pkg::cmd_t cmd
);
  import leds_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && sts.in_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.found) state_next = ST_EMIT;
        else if (!sts.flipped) state_next = ST_SCAN;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_ready) state_next = sts.out_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    cmd.accept    = (state == ST_IDLE) && in_valid;
    cmd.start     = (state == ST_IDLE) && in_valid && sts.in_last;
    cmd.scan      = (state == ST_SCAN);
    cmd.serve     = (state == ST_DECIDE) && sts.found;
    cmd.flip      = (state == ST_DECIDE) && !sts.found && !sts.flipped;
    cmd.next_scan = (state == ST_EMIT) && out_ready && !sts.out_last;
    cmd.clear     = ((state == ST_EMIT) && out_ready && sts.out_last) ||
                    ((state == ST_DECIDE) && !sts.found && sts.flipped);
  end

endmodule

>>> rtl/leds_dp.sv
// Datapath: config registers, pending table, valid bits, scan compare,
// head/seek arithmetic and output register. Depends on leds_pkg, leds_ram.
`timescale 1ns / 1ps

module leds_dp #(
  parameter int unsigned MAX_REQUESTS = 16,
  parameter int unsigned TRACK_BITS   = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [leds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [TRACK_BITS-1:0]           cfg_data,
  input  logic [TRACK_BITS-1:0]           request_track,
  input  logic                            batch_end,
  input  leds_pkg::cmd_t                  cmd,
  output leds_pkg::sts_t                  sts,
  output logic [TRACK_BITS-1:0]           served_track,
  output logic [TRACK_BITS-1:0]           distance_moved,
  output logic [leds_pkg::SEEK_W-1:0]     seek_total,
  output logic                            run_last
);
  import leds_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_REQUESTS);
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned SUM_W = ((TRACK_BITS > SEEK_W) ? TRACK_BITS : SEEK_W) + 1;

  logic [TRACK_BITS-1:0]   start_position;
  logic                    start_upward;
  logic [CNT_W-1:0]        loaded_count, loaded_count_next;
  logic [MAX_REQUESTS-1:0] pending_valid;
  logic [TRACK_BITS-1:0]   head_position;
  logic                    moving_up;
  logic [SEEK_W-1:0]       seek_acc, seek_next;
  logic [CNT_W-1:0]        remaining;
  logic [IDX_W-1:0]        scan_idx;
  logic                    cmp_en;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    found;
  logic                    flipped;
  logic [TRACK_BITS-1:0]   best_track;
  logic [IDX_W-1:0]        best_idx;
  logic [TRACK_BITS-1:0]   rd_track;
  logic                    store;
  logic                    better;
  logic                    scan_begin;
  logic [TRACK_BITS-1:0]   step_dist;
  logic [SUM_W-1:0]        seek_sum;

  assign store = cmd.accept && (loaded_count < CNT_W'(MAX_REQUESTS));
  assign loaded_count_next = store ? loaded_count + CNT_W'(1) : loaded_count;
  assign scan_begin = cmd.start || cmd.flip || cmd.next_scan;

  leds_ram #(.WIDTH(TRACK_BITS), .DEPTH(MAX_REQUESTS)) u_pending (
    .clk   (clk),
    .we    (store),
    .waddr (loaded_count[IDX_W-1:0]),
    .wdata (request_track),
    .raddr (scan_idx),
    .rdata (rd_track)
  );

  always_comb begin
    if (moving_up) begin
      better = (rd_track >= head_position) && (!found || (rd_track < best_track));
    end else begin
      better = (rd_track <= head_position) && (!found || (rd_track > best_track));
    end
    better = better && cmp_en && pending_valid[cmp_idx];

    step_dist = (best_track >= head_position) ? best_track - head_position
                                              : head_position - best_track;
    seek_sum = SUM_W'(seek_acc) + SUM_W'(step_dist);
    seek_next = (seek_sum > SUM_W'(SEEK_MAX)) ? SEEK_W'(SEEK_MAX) : seek_sum[SEEK_W-1:0];
  end

  always_comb begin
    sts.in_last  = batch_end;
    sts.scan_end = (CNT_W'(scan_idx) == loaded_count - CNT_W'(1));
    sts.found    = found;
    sts.flipped  = flipped;
    sts.out_last = run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= TRACK_BITS'(50);
      start_upward   <= 1'b1;
      loaded_count   <= '0;
      pending_valid  <= '0;
      scan_idx       <= '0;
      cmp_en         <= 1'b0;
      found          <= 1'b0;
      flipped        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_POSITION: start_position <= cfg_data;
          REG_START_UPWARD:   start_upward   <= cfg_data[0];
          default: ;
        endcase
      end
      cmp_en <= cmd.scan;
      if (store) begin
        pending_valid[loaded_count[IDX_W-1:0]] <= 1'b1;
      end
      if (scan_begin) begin
        scan_idx <= '0;
        found    <= 1'b0;
        flipped  <= cmd.flip;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (better) begin
        found <= 1'b1;
      end
      if (cmd.serve) begin
        pending_valid[best_idx] <= 1'b0;
      end
      if (cmd.clear) begin
        pending_valid <= '0;
        loaded_count  <= '0;
      end else begin
        loaded_count  <= loaded_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (better) begin
      best_track <= rd_track;
      best_idx   <= cmp_idx;
    end
    if (cmd.start) begin
      head_position <= start_position;
      moving_up     <= start_upward;
      seek_acc      <= '0;
      remaining     <= loaded_count_next;
    end
    if (cmd.flip) begin
      moving_up <= !moving_up;
    end
    if (cmd.serve) begin
      head_position  <= best_track;
      seek_acc       <= seek_next;
      remaining      <= remaining - CNT_W'(1);
      served_track   <= best_track;
      distance_moved <= step_dist;
      seek_total     <= seek_next;
      run_last       <= (remaining == CNT_W'(1));
    end
  end

endmodule

>>> rtl/look_elevator_disk_scheduler_core.sv
// Top level of the LOOK elevator disk scheduler: controller plus datapath.
// Depends on leds_pkg, leds_if, leds_ram, leds_ctrl, leds_dp.
//
//   channel | dir | fields                                         | handshake
//   req     | in  | request_track, batch_end                       | valid/ready
//   res     | out | served_track, distance_moved, seek_total, run_last | valid/ready
//   cfg     | in  | cfg_index, cfg_data                            | cfg_we only
//
// Request words are taken only while the controller is idle. After the batch_end
// word, each result needs one sweep of the pending table through its single
// read port, a second sweep when the direction reverses, and a wait in the
// output register until it is taken. No request is taken while a batch is
// being served. rst is synchronous; config resets to 50 / upward.
`timescale 1ns / 1ps

module look_elevator_disk_scheduler_core #(
  parameter int unsigned MAX_REQUESTS = 16,
  parameter int unsigned TRACK_BITS   = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [leds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [TRACK_BITS-1:0]          cfg_data,
  leds_req_if.sink                       req,
  leds_res_if.source                     res
);
  import leds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  leds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  leds_dp #(.MAX_REQUESTS(MAX_REQUESTS), .TRACK_BITS(TRACK_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .request_track  (req.request_track),
    .batch_end      (req.batch_end),
    .cmd            (cmd),
    .sts            (sts),
    .served_track   (res.served_track),
    .distance_moved (res.distance_moved),
    .seek_total     (res.seek_total),
    .run_last       (res.run_last)
  );

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready)
    else $error("request ready while a result word is pending");

  a_idle_after_run: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && res.run_last) |=> req.ready)
    else $error("not idle after final result word");

  a_busy_after_batch_end: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.batch_end) |=> !req.ready)
    else $error("request ready right after batch end word");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for look_elevator_disk_scheduler_core: directed and
// random request batches, a LOOK-order predictor and a field-by-field check
// of every result word. Depends on leds_pkg, leds_if and the scheduler RTL.
`timescale 1ns / 1ps

module tb_top;
  import leds_pkg::*;

  localparam int unsigned MAX_REQ = 16;
  localparam int unsigned TRK_W   = 10;
  localparam int unsigned SETTLE  = 50;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic [TRK_W-1:0] track;
    logic             last;
  } req_word_t;

  typedef struct packed {
    logic [TRK_W-1:0]  track;
    logic [TRK_W-1:0]  step_dist;
    logic [SEEK_W-1:0] seek;
    logic              last;
  } service_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [TRK_W-1:0] cfg_data;

  leds_req_if #(.TRACK_BITS(TRK_W)) req_ch ();
  leds_res_if #(.TRACK_BITS(TRK_W)) res_ch ();

  look_elevator_disk_scheduler_core #(
    .MAX_REQUESTS(MAX_REQ),
    .TRACK_BITS  (TRK_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  always #5 clk = ~clk;

  req_word_t        request_words_q[$];
  service_t         service_order_q[$];
  logic [TRK_W-1:0] held_track[MAX_REQ];
  int               held_count = 0;
  logic [TRK_W-1:0] cfg_start_pos = 10'd50;
  logic             cfg_start_up  = 1'b1;
  int               sender_idle_pct   = 0;
  int               receiver_stall_pct = 0;
  logic             hold_start = 1'b0;
  int               hold_left;
  int               mismatches = 0;
  req_word_t        next_word;
  service_t         want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
    mismatches++;
  endtask

  function automatic int nearest_pending(input logic [MAX_REQ-1:0] live,
                                         input logic [TRK_W-1:0] head, input logic up);
    int best;
    best = -1;
    for (int i = 0; i < MAX_REQ; i++) begin
      if (live[i]) begin
        if (up) begin
          if (held_track[i] >= head && (best < 0 || held_track[i] < held_track[best]))
            best = i;
        end else begin
          if (held_track[i] <= head && (best < 0 || held_track[i] > held_track[best]))
            best = i;
        end
      end
    end
    return best;
  endfunction

  // store one request; on batch end, predict the whole LOOK sweep
  task automatic absorb_request(input logic [TRK_W-1:0] track, input logic last);
    logic [MAX_REQ-1:0] live;
    logic [TRK_W-1:0]   head;
    logic [TRK_W-1:0]   step_dist;
    logic               up;
    int                 seek;
    int                 left;
    int                 pick;
    service_t           s;
    if (held_count < MAX_REQ) begin
      held_track[held_count] = track;
      held_count++;
    end
    if (last) begin
      live = '0;
      for (int i = 0; i < held_count; i++) live[i] = 1'b1;
      head = cfg_start_pos;
      up   = cfg_start_up;
      seek = 0;
      left = held_count;
      while (left > 0) begin
        pick = nearest_pending(live, head, up);
        if (pick < 0) begin
          up   = !up;
          pick = nearest_pending(live, head, up);
        end
        if (pick < 0) break;
        step_dist = (held_track[pick] >= head) ? held_track[pick] - head
                                               : head - held_track[pick];
        seek += int'(step_dist);
        if (seek > int'(SEEK_MAX)) seek = int'(SEEK_MAX);
        head = held_track[pick];
        live[pick] = 1'b0;
        left--;
        s.track     = head;
        s.step_dist = step_dist;
        s.seek      = seek[SEEK_W-1:0];
        s.last      = (left == 0);
        service_order_q.push_back(s);
      end
      held_count = 0;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        absorb_request(req_ch.request_track, req_ch.batch_end);
      if (!req_ch.valid || req_ch.ready) begin
        if (request_words_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word = request_words_q.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.request_track <= next_word.track;
          req_ch.batch_end     <= next_word.last;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (service_order_q.size() == 0) begin
          report_mismatch("unexpected word, track", int'(res_ch.served_track), -1);
        end else begin
          want = service_order_q.pop_front();
          if (res_ch.served_track !== want.track)
            report_mismatch("served_track", int'(res_ch.served_track), int'(want.track));
          if (res_ch.distance_moved !== want.step_dist)
            report_mismatch("distance_moved", int'(res_ch.distance_moved),
                            int'(want.step_dist));
          if (res_ch.seek_total !== want.seek)
            report_mismatch("seek_total", int'(res_ch.seek_total), int'(want.seek));
          if (res_ch.run_last !== want.last)
            report_mismatch("run_last", int'(res_ch.run_last), int'(want.last));
        end
      end
      if (hold_start || hold_left != 0)
        res_ch.ready <= 1'b0;
      else
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [TRK_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_START_POSITION) cfg_start_pos = val;
    else cfg_start_up = val[0];
  endtask

  task automatic set_start(input logic [TRK_W-1:0] pos, input logic up);
    write_reg(REG_START_POSITION, pos);
    write_reg(REG_START_UPWARD, {{(TRK_W-1){1'b0}}, up});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (request_words_q.size() != 0 || req_ch.valid || service_order_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_word(input logic [TRK_W-1:0] track, input logic last);
    req_word_t w;
    w.track = track;
    w.last  = last;
    request_words_q.push_back(w);
  endtask

  // one batch with random content; a few run past capacity
  task automatic queue_random_batch(output int len);
    logic [TRK_W-1:0] t;
    logic [TRK_W-1:0] prev;
    prev = TRK_W'($urandom_range(1023));
    len = ($urandom_range(99) < 10) ? int'($urandom_range(20, 17))
                                    : int'($urandom_range(16, 1));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: t = '0;
        1: t = '1;
        2: t = cfg_start_pos;
        3: t = prev;
        4: t = cfg_start_pos + TRK_W'($urandom_range(6)) - TRK_W'(3);
        default: t = TRK_W'($urandom_range(1023));
      endcase
      push_word(t, i == len - 1);
      prev = t;
    end
  endtask

  initial begin
    int got;
    int phase_items;
    req_ch.valid         = 1'b0;
    req_ch.request_track = '0;
    req_ch.batch_end     = 1'b0;
    res_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = REG_START_POSITION;
    cfg_data             = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset start (50, upward)
    push_word(10'd0, 1'b1);
    push_word(10'd1023, 1'b0);
    push_word(10'd0, 1'b0);
    push_word(10'd50, 1'b0);
    push_word(10'd50, 1'b0);
    push_word(10'd512, 1'b1);
    for (int i = 0; i < 18; i++)
      push_word(TRK_W'((i * 397 + 5) % 1024), i == 17);
    wait_drained();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: set_start(10'd0, 1'b0);
        2: set_start(10'd1023, 1'b1);
        3: set_start(10'd1023, 1'b0);
        4: set_start(10'd0, 1'b1);
        default: set_start(TRK_W'($urandom_range(1023)), 1'($urandom_range(1)));
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
      endcase
      phase_items = 0;
      while (phase_items < 53) begin
        queue_random_batch(got);
        phase_items += got;
      end
      // stall results while the sender keeps offering, so input backs up
      if (p % 4 == 3) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      // sender then sits idle until every result is back
      wait_drained();
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/leds_pkg.sv
rtl/leds_if.sv
rtl/leds_ram.sv
rtl/leds_ctrl.sv
rtl/leds_dp.sv
rtl/look_elevator_disk_scheduler_core.sv
bench/tb_top.sv
